[design/stepper_ramp_step_generator_macros.svh]
// Assertion macros for the stepper ramp step generator
`ifndef STEPPER_RAMP_STEP_GENERATOR_MACROS_SVH
`define STEPPER_RAMP_STEP_GENERATOR_MACROS_SVH

// Check that post holds in the same cycle as pre
`define SRSG_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("stepper ramp step generator check failed");

// Check that post holds in the cycle after pre
`define SRSG_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("stepper ramp step generator check failed");

`endif

[design/srsg_pkg.sv]
// Types and constants shared by the stepper ramp step generator
package srsg_pkg;

    localparam int CMD_BITS    = 2;
    localparam int TARGET_BITS = 32;
    localparam int POS_OUT_BITS = 32;
    localparam int PERIOD_BITS = 16;
    localparam int RAMP_BITS   = 10;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [PERIOD_BITS-1:0] SLOW_PERIOD_RESET    = 16'd2000;
    localparam logic [PERIOD_BITS-1:0] FAST_PERIOD_RESET    = 16'd200;
    localparam logic [PERIOD_BITS-1:0] DECEL_DISTANCE_RESET = 16'd100;
    localparam logic [RAMP_BITS-1:0]   RAMP_INCREMENT_RESET = 10'd10;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_TICK = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_STOP = 2'd2,
        CMD_ZERO = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SLOW_PERIOD    = 2'd0,
        CFG_FAST_PERIOD    = 2'd1,
        CFG_DECEL_DISTANCE = 2'd2,
        CFG_RAMP_INCREMENT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [PERIOD_BITS-1:0] slow_period;
        logic [PERIOD_BITS-1:0] fast_period;
        logic [PERIOD_BITS-1:0] decel_distance;
        logic [RAMP_BITS-1:0]   ramp_increment;
    } cfg_t;

    typedef struct packed {
        cmd_t                   command;
        logic [TARGET_BITS-1:0] target_position;
    } cmd_item_t;

    typedef struct packed {
        logic                    step_level;
        logic                    direction;
        logic                    driver_enabled;
        logic                    moving;
        logic [POS_OUT_BITS-1:0] position;
        logic [PERIOD_BITS-1:0]  step_period;
    } result_t;

endpackage

[design/srsg_cmd_if.sv]
// Command channel interface: valid/ready with command and target
interface srsg_cmd_if import srsg_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [CMD_BITS-1:0]           command;
    logic signed [TARGET_BITS-1:0] target_position;

    modport source (output valid, output command, output target_position, input ready);
    modport sink (input valid, input command, input target_position, output ready);
endinterface

[design/srsg_result_if.sv]
// Result channel interface: valid/ready with step outputs and position
interface srsg_result_if import srsg_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic                           step_level;
    logic                           direction;
    logic                           driver_enabled;
    logic                           moving;
    logic signed [POS_OUT_BITS-1:0] position;
    logic [PERIOD_BITS-1:0]         step_period;

    modport source (
        output valid, output step_level, output direction, output driver_enabled,
        output moving, output position, output step_period, input ready
    );
    modport sink (
        input valid, input step_level, input direction, input driver_enabled,
        input moving, input position, input step_period, output ready
    );
endinterface

[design/srsg_cfg_if.sv]
// Configuration write channel interface: valid/ready with index and data
interface srsg_cfg_if import srsg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[design/srsg_cfg_regs.sv]
// Configuration register file for the stepper ramp step generator
module srsg_cfg_regs import srsg_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    srsg_cfg_if.sink   cfg,
    output cfg_t       regs
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_SLOW_PERIOD:    cfg_next.slow_period    = cfg.data;
                CFG_FAST_PERIOD:    cfg_next.fast_period    = cfg.data;
                CFG_DECEL_DISTANCE: cfg_next.decel_distance = cfg.data;
                CFG_RAMP_INCREMENT: cfg_next.ramp_increment = cfg.data[RAMP_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_period    <= SLOW_PERIOD_RESET;
            cfg_reg.fast_period    <= FAST_PERIOD_RESET;
            cfg_reg.decel_distance <= DECEL_DISTANCE_RESET;
            cfg_reg.ramp_increment <= RAMP_INCREMENT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[design/srsg_motion.sv]
// Motion state and single-pass update: step timer, position, period ramp
module srsg_motion import srsg_pkg::*; #(
    parameter int POSITION_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      step_en,
    input  cmd_item_t item,
    output result_t   result
);

    logic signed [POSITION_BITS-1:0] cur_reg, cur_next;
    logic signed [POSITION_BITS-1:0] goal_reg, goal_next;
    logic                            run_reg, run_next;
    logic                            phase_reg, phase_next;
    logic [PERIOD_BITS-1:0]          period_reg, period_next;
    logic [PERIOD_BITS-1:0]          tick_reg, tick_next;
    logic                            dir_reg, dir_next;
    logic                            en_reg, en_next;

    logic [PERIOD_BITS-1:0]          tick_inc;
    logic signed [POSITION_BITS:0]   diff;
    logic                            step_up;
    logic                            step_down;
    logic                            arrive;
    logic                            near;
    logic [POSITION_BITS-1:0]        decel_ext;
    logic [PERIOD_BITS:0]            grown;
    logic [PERIOD_BITS-1:0]          above_fast;
    logic signed [POSITION_BITS-1:0] target_ext;

    assign tick_inc   = tick_reg + 1'b1;
    assign diff       = {goal_reg[POSITION_BITS-1], goal_reg} - {cur_reg[POSITION_BITS-1], cur_reg};
    assign step_down  = diff[POSITION_BITS];
    assign step_up    = !diff[POSITION_BITS] && (diff != '0);
    assign arrive     = (diff == '0) || (diff == (POSITION_BITS+1)'(1)) || (diff == '1);
    assign decel_ext  = POSITION_BITS'(cfg.decel_distance);
    assign near       = step_up ? (diff[POSITION_BITS-1:0] <= decel_ext)
                                : (~diff[POSITION_BITS-1:0] < decel_ext);
    assign grown      = {1'b0, period_reg} + (PERIOD_BITS+1)'(cfg.ramp_increment);
    assign above_fast = period_reg - cfg.fast_period;
    assign target_ext = POSITION_BITS'($signed(item.target_position));

    always_comb
    begin
        cur_next    = cur_reg;
        goal_next   = goal_reg;
        run_next    = run_reg;
        phase_next  = phase_reg;
        period_next = period_reg;
        tick_next   = tick_reg;
        dir_next    = dir_reg;
        en_next     = en_reg;
        case (item.command)
            CMD_TICK:
            begin
                if (run_reg)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= period_reg)
                    begin
                        tick_next = '0;
                        if (!phase_reg)
                        begin
                            phase_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = 1'b0;
                            if (step_up)
                            begin
                                cur_next = cur_reg + 1'b1;
                            end
                            else if (step_down)
                            begin
                                cur_next = cur_reg - 1'b1;
                            end
                            if (arrive)
                            begin
                                run_next = 1'b0;
                            end
                            else if (near)
                            begin
                                period_next = (grown > {1'b0, cfg.slow_period}) ?
                                              cfg.slow_period : grown[PERIOD_BITS-1:0];
                            end
                            else if (period_reg > cfg.fast_period)
                            begin
                                period_next = (above_fast <= PERIOD_BITS'(cfg.ramp_increment)) ?
                                              cfg.fast_period :
                                              period_reg - PERIOD_BITS'(cfg.ramp_increment);
                            end
                        end
                    end
                end
            end
            CMD_MOVE:
            begin
                goal_next = target_ext;
                if (target_ext != cur_reg)
                begin
                    dir_next    = (target_ext > cur_reg);
                    en_next     = 1'b1;
                    run_next    = 1'b1;
                    period_next = cfg.slow_period;
                    tick_next   = '0;
                end
            end
            CMD_STOP:
            begin
                run_next   = 1'b0;
                phase_next = 1'b0;
                en_next    = 1'b0;
            end
            CMD_ZERO:
            begin
                cur_next  = '0;
                goal_next = '0;
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_comb
    begin
        result.step_level     = phase_next;
        result.direction      = dir_next;
        result.driver_enabled = en_next;
        result.moving         = run_next;
        result.position       = POS_OUT_BITS'(cur_next);
        result.step_period    = period_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            goal_reg   <= '0;
            run_reg    <= 1'b0;
            phase_reg  <= 1'b0;
            period_reg <= SLOW_PERIOD_RESET;
            tick_reg   <= '0;
            dir_reg    <= 1'b0;
            en_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            cur_reg    <= cur_next;
            goal_reg   <= goal_next;
            run_reg    <= run_next;
            phase_reg  <= phase_next;
            period_reg <= period_next;
            tick_reg   <= tick_next;
            dir_reg    <= dir_next;
            en_reg     <= en_next;
        end
    end

endmodule

[design/stepper_ramp_step_generator.sv]
// Top level of the stepper ramp step generator: channel stages and motion core
//
// Commands enter on cmd (valid/ready): tick, move to target_position, stop, or
// zero the position. Every command transfer yields exactly one result on res,
// carrying the step level, direction, driver enable, moving flag, position and
// current half-period as they stand after that command.
// A cmd transfer reaches res valid through one input register, then the motion
// update that writes the state and the result register on the same edge.
// Throughput is one command per cycle while res is not stalled; the state
// update loop closes through the motion registers.
// When res is stalled, the result register holds, the input register fills and
// cmd.ready drops; no command is lost and flow resumes without a gap.
// Configuration writes on cfg are taken every cycle (ready always high) and
// should be issued only while no command is in flight.
// Reset clears both stages, sets position and goal to zero, stops and disables
// the driver, and loads the period registers with their reset values.
`include "stepper_ramp_step_generator_macros.svh"

module stepper_ramp_step_generator import srsg_pkg::*; #(
    parameter int POSITION_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    srsg_cmd_if.sink     cmd,
    srsg_result_if.source res,
    srsg_cfg_if.sink     cfg
);

    cfg_t      cfg_regs;
    cmd_item_t in_item_reg;
    logic      in_valid_reg;
    result_t   res_reg;
    logic      res_valid_reg;
    result_t   core_result;
    logic      advance;
    logic      step_en;

    assign advance   = !res_valid_reg || res.ready;
    assign step_en   = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;

    srsg_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    srsg_motion #(
        .POSITION_BITS (POSITION_BITS)
    ) u_motion (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_regs),
        .step_en (step_en),
        .item    (in_item_reg),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_item_reg.command         <= cmd_t'(cmd.command);
            in_item_reg.target_position <= cmd.target_position;
        end
        if (step_en)
        begin
            res_reg <= core_result;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.step_level     = res_reg.step_level;
    assign res.direction      = res_reg.direction;
    assign res.driver_enabled = res_reg.driver_enabled;
    assign res.moving         = res_reg.moving;
    assign res.position       = res_reg.position;
    assign res.step_period    = res_reg.step_period;

    // hold the input stage while a full result stalls
    `SRSG_ASSERT_SAME(a_stall_blocks_input, in_valid_reg && res_valid_reg && !res.ready, !cmd.ready)
    // a command transfer always lands in the input stage
    `SRSG_ASSERT_NEXT(a_transfer_lands, cmd.valid && cmd.ready, in_valid_reg)
    // a running move keeps the driver enabled
    `SRSG_ASSERT_SAME(a_moving_enabled, res.valid && res.moving, res.driver_enabled)
    // the step output rests low when no move runs
    `SRSG_ASSERT_SAME(a_idle_step_low, res.valid && !res.moving, !res.step_level)

endmodule
